// File: sv/huffman_code_bit_packer_macros.svh
// ----------------------------------------------------------------------------
// Huffman code bit packer: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// Condition must hold in the same cycle as the trigger
`define HCBP_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger
`define HCBP_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: sv/hcbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pkg
// Constants, opcodes and shared types of the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // Table geometry
  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOLS      = 256;
  localparam int SYM_AW       = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int SYM_W   = 8;
  localparam int CBITS_W = 32;
  localparam int CLEN_W  = 6;
  localparam int BYTE_W  = 8;

  // Stored code and bit accumulator
  localparam int CODE_W = MAX_CODE_LEN;
  localparam int ACC_W  = MAX_CODE_LEN + BYTE_W - 1;
  localparam int CNT_W  = $clog2(ACC_W + 1);

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  // One request for the packer
  typedef struct packed {
    logic              flush;
    logic [CLEN_W-1:0] len;
    logic [CODE_W-1:0] code;
  } cmd_t;

  // Packer status
  typedef struct packed {
    logic             flush_taken;
    logic [CNT_W-1:0] pend_cnt;
  } back_stat_t;

endpackage

// File: sv/hcbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/hcbp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts requests, keeps the code table and turns encodes and flushes into
// packer commands.
// ----------------------------------------------------------------------------
module hcbp_front import hcbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [OP_W-1:0]    op_i,
  input  logic [SYM_W-1:0]   symbol_i,
  input  logic [CBITS_W-1:0] code_bits_i,
  input  logic [CLEN_W-1:0]  code_length_i,
  input  logic [QCNT_W-1:0]  q_count_i,
  output logic               q_push_o,
  output cmd_t               q_cmd_o
);

  logic               accept;
  logic               sym_ok;
  logic [SYM_AW-1:0]  addr;
  logic [CLEN_W-1:0]  len_sat;
  logic [63:0]        mask64;
  logic [CODE_W-1:0]  code_masked;
  logic               table_we;
  logic [SYMBOLS-1:0] valid_q, valid_d;
  logic               s1_enc_q, s1_enc_d;
  logic               s1_flush_q, s1_flush_d;
  logic [CODE_W-1:0]  code_rd;
  logic [CLEN_W-1:0]  len_rd;

  assign accept = push_i && !full_o;
  assign sym_ok = (32'(symbol_i) < SYMBOLS);
  assign addr   = symbol_i[SYM_AW-1:0];

  // Saturate the length and drop code bits above it
  always_comb begin
    len_sat     = (code_length_i > CLEN_W'(MAX_CODE_LEN)) ? CLEN_W'(MAX_CODE_LEN)
                                                          : code_length_i;
    mask64      = (64'd1 << len_sat) - 64'd1;
    code_masked = CODE_W'(code_bits_i & mask64[CBITS_W-1:0]);
    table_we    = accept && (op_i == OP_LOAD) && sym_ok;
  end

  hcbp_ram #(.Width(CODE_W), .Depth(SYMBOLS)) u_code_ram (
    .clk_i  (clk_i),
    .we_i   (table_we),
    .waddr_i(addr),
    .wdata_i(code_masked),
    .raddr_i(addr),
    .rdata_o(code_rd)
  );

  hcbp_ram #(.Width(CLEN_W), .Depth(SYMBOLS)) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (table_we),
    .waddr_i(addr),
    .wdata_i(len_sat),
    .raddr_i(addr),
    .rdata_o(len_rd)
  );

  // Mark loaded entries; classify the request for the lookup stage
  always_comb begin
    valid_d = valid_q;
    if (table_we) begin
      valid_d[addr] = 1'b1;
    end
    s1_enc_d   = accept && (op_i == OP_ENCODE) && sym_ok && valid_q[addr];
    s1_flush_d = accept && (op_i == OP_FLUSH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      s1_enc_q   <= 1'b0;
      s1_flush_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      s1_enc_q   <= s1_enc_d;
      s1_flush_q <= s1_flush_d;
    end
  end

  // Build the command; drop encodes with no code
  always_comb begin
    q_cmd_o.flush = s1_flush_q;
    q_cmd_o.len   = s1_enc_q ? len_rd : '0;
    q_cmd_o.code  = code_rd;
    q_push_o      = s1_flush_q || (s1_enc_q && (len_rd != '0));
  end

  // Hold off while the queue could not take the request in flight
  assign full_o = (q_count_i + QCNT_W'(s1_enc_q || s1_flush_q)) >= QCNT_W'(QDEPTH);

endmodule

// File: sv/hcbp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_fifo
// Short command queue between the table front and the bit packer.
// ----------------------------------------------------------------------------
module hcbp_fifo import hcbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cmd_t              cmd_i,
  input  logic              pop_i,
  output logic              valid_o,
  output cmd_t              cmd_o,
  output logic [QCNT_W-1:0] count_o
);

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// File: sv/hcbp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_back
// Bit packer: appends codes to the accumulator and emits one byte per cycle
// into the result register while that register can take one.
// ----------------------------------------------------------------------------
module hcbp_back import hcbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cmd_t              q_cmd_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [BYTE_W-1:0] packed_byte_o,
  output logic              last_of_run_o,
  output back_stat_t        stat_o
);

  logic [ACC_W-1:0]  work_q, work_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic              out_ready;
  logic              draining;
  logic              emit_enc;
  logic              emit_flush;
  logic [CNT_W-1:0]  rem_cnt;
  logic [ACC_W-1:0]  rem_bits;
  logic [ACC_W-1:0]  base_bits;
  logic [CNT_W-1:0]  base_cnt;
  logic              settled;
  logic              flush_needs_out;
  logic              take;

  always_comb begin
    // Drain full bytes while the result register can take one
    out_ready = !out_valid_q || pop_i;
    draining  = cnt_q >= CNT_W'(BYTE_W);
    emit_enc  = draining && out_ready;
    rem_cnt   = cnt_q - CNT_W'(BYTE_W);
    rem_bits  = work_q & ((ACC_W'(1) << rem_cnt) - ACC_W'(1));
    base_bits = emit_enc ? rem_bits : work_q;
    base_cnt  = emit_enc ? rem_cnt : cnt_q;
    settled   = emit_enc ? (rem_cnt < CNT_W'(BYTE_W)) : !draining;

    // Take the next request once fewer than eight bits remain
    flush_needs_out = q_cmd_i.flush && (base_cnt != '0);
    take       = q_valid_i && settled &&
                 (!flush_needs_out || (!emit_enc && out_ready));
    emit_flush = take && flush_needs_out;

    work_d = base_bits;
    cnt_d  = base_cnt;
    if (take) begin
      if (q_cmd_i.flush) begin
        work_d = '0;
        cnt_d  = '0;
      end else begin
        work_d = (base_bits << q_cmd_i.len) | ACC_W'(q_cmd_i.code);
        cnt_d  = base_cnt + CNT_W'(q_cmd_i.len);
      end
    end
  end

  // Select the byte for the result register
  always_comb begin
    if (emit_enc) begin
      byte_d = BYTE_W'(work_q >> rem_cnt);
      last_d = (rem_cnt < CNT_W'(BYTE_W));
    end else begin
      byte_d = work_q[BYTE_W-1:0] << (3'd0 - cnt_q[2:0]);
      last_d = 1'b1;
    end
    out_valid_d = emit_enc || emit_flush || (out_valid_q && !pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      work_q      <= work_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (emit_enc || emit_flush) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign q_pop_o            = take;
  assign empty_o            = !out_valid_q;
  assign packed_byte_o      = byte_q;
  assign last_of_run_o      = last_q;
  assign stat_o.flush_taken = take && q_cmd_i.flush;
  assign stat_o.pend_cnt    = cnt_q;

endmodule

// File: sv/huffman_code_bit_packer.sv
`timescale 1ns / 1ps
// Huffman code bit packer. Load requests (op 0) fill a 256-entry code table,
// encode requests (op 1) append the symbol's code MSB first to a bit
// accumulator and yield each completed byte, flush requests (op 2) yield the
// last partial byte padded with zeros. A request is taken every cycle while
// the four-entry command queue has room; loads never reach the packer. The
// packer yields one byte per cycle through the result register while that
// register is free or being popped. A taken request passes through the
// table read stage and the command queue before it reaches the packer. No
// clearing pass is needed after reset: per-entry valid bits cover the length
// table.
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Top level: table front, command queue and bit packer.
// ----------------------------------------------------------------------------
`include "huffman_code_bit_packer_macros.svh"

module huffman_code_bit_packer import hcbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [OP_W-1:0]    op_i,
  input  logic [SYM_W-1:0]   symbol_i,
  input  logic [CBITS_W-1:0] code_bits_i,
  input  logic [CLEN_W-1:0]  code_length_i,
  output logic               empty,
  input  logic               pop,
  output logic [BYTE_W-1:0]  packed_byte_o,
  output logic               last_of_run_o
);

  logic              q_push;
  cmd_t              q_cmd_in;
  logic              q_valid;
  cmd_t              q_cmd_out;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;
  back_stat_t        back_stat;

  hcbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .op_i         (op_i),
    .symbol_i     (symbol_i),
    .code_bits_i  (code_bits_i),
    .code_length_i(code_length_i),
    .q_count_i    (q_count),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd_in)
  );

  hcbp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd_in),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (q_cmd_out),
    .count_o(q_count)
  );

  hcbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd_out),
    .q_pop_o      (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .packed_byte_o(packed_byte_o),
    .last_of_run_o(last_of_run_o),
    .stat_o       (back_stat)
  );

  // Queue credit must never let a request in past the depth
  `HCBP_ASSERT_NOW(a_q_no_overflow, q_push && !q_pop, q_count < QCNT_W'(QDEPTH), "queue overflow")
  `HCBP_ASSERT_NOW(a_q_count_range, 1'b1, q_count <= QCNT_W'(QDEPTH), "queue count out of range")
  // A taken flush leaves nothing pending
  `HCBP_ASSERT_NEXT(a_flush_clears, back_stat.flush_taken, back_stat.pend_cnt == '0, "flush left bits")
  // Accumulator never holds more than a code plus seven pending bits
  `HCBP_ASSERT_NOW(a_acc_bound, 1'b1, back_stat.pend_cnt <= CNT_W'(ACC_W), "accumulator overrun")

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the Huffman code bit packer. A driver pushes load, encode,
// flush and unused-op requests from a pending queue. A built-in packing model
// works out the bytes each request must yield. A monitor pops results and
// checks each byte and its end-of-run flag in order. Both sides idle in random
// bursts, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_top;
  import hcbp_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 24;
  localparam int QUIET_ITEMS    = 25;
  localparam int RANDOM_ITEMS   = 88;
  localparam int ALPHABET       = 8;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SYM_W-1:0]   symbol;
    logic [CBITS_W-1:0] code_bits;
    logic [CLEN_W-1:0]  code_length;
    logic               drain;
  } request_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last_flag;
  } packed_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [OP_W-1:0]    op_i = '0;
  logic [SYM_W-1:0]   symbol_i = '0;
  logic [CBITS_W-1:0] code_bits_i = '0;
  logic [CLEN_W-1:0]  code_length_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [BYTE_W-1:0]  packed_byte_o;
  logic               last_of_run_o;

  // Packing model state
  logic [CODE_W-1:0] code_tbl [SYMBOLS];
  logic [CLEN_W-1:0] len_tbl [SYMBOLS];
  logic [6:0]        pend_bits = '0;
  logic [2:0]        pend_cnt = '0;

  request_t       request_q[$];
  packed_result_t packed_byte_q[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  timed_out = 1'b0;
  bit  quiet_phase = 1'b0;
  int  push_gap = 0;
  int  pop_gap = 0;
  int  push_idle_pct = 0;
  int  pop_idle_pct = 0;
  int  taken = 0;
  int  popped = 0;

  huffman_code_bit_packer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .empty         (empty),
    .pop           (pop),
    .packed_byte_o (packed_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  initial forever #5 clk_i = ~clk_i;

  function automatic logic [63:0] low_ones(input int unsigned n);
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  // Apply one request to the model and queue the bytes it must yield
  function automatic void predict_packed_bytes(input request_t rq);
    logic [CLEN_W-1:0] len;
    logic [63:0]       acc;
    int unsigned       count;
    packed_result_t    res;
    int                n;
    n = 0;
    case (rq.op)
      OP_LOAD: begin
        len = (rq.code_length > MAX_CODE_LEN) ? CLEN_W'(MAX_CODE_LEN) : rq.code_length;
        code_tbl[rq.symbol] = CODE_W'({32'd0, rq.code_bits} & low_ones(len));
        len_tbl[rq.symbol] = len;
      end
      OP_ENCODE: begin
        len = len_tbl[rq.symbol];
        if (len != 0) begin
          acc = ({57'd0, pend_bits} << len) | ({32'd0, code_tbl[rq.symbol]} & low_ones(len));
          count = pend_cnt + len;
          while (count >= 8) begin
            count -= 8;
            res.data = BYTE_W'(acc >> count);
            res.last_flag = 1'b0;
            packed_byte_q = {packed_byte_q, res};
            n++;
          end
          if (n > 0) packed_byte_q[packed_byte_q.size() - 1].last_flag = 1'b1;
          pend_cnt = 3'(count);
          pend_bits = 7'(acc & low_ones(count));
        end
      end
      OP_FLUSH: begin
        if (pend_cnt != 0) begin
          res.data = BYTE_W'({1'b0, pend_bits} << (8 - pend_cnt));
          res.last_flag = 1'b1;
          packed_byte_q = {packed_byte_q, res};
          pend_bits = '0;
          pend_cnt = '0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic add_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                             input logic [CBITS_W-1:0] bits, input logic [CLEN_W-1:0] len,
                             input logic drain);
    request_t rq;
    rq.op = op;
    rq.symbol = sym;
    rq.code_bits = bits;
    rq.code_length = len;
    rq.drain = drain;
    request_q = {request_q, rq};
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Drive requests: retire the accepted one, then present the next
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        predict_packed_bytes(request_q[0]);
        void'(request_q.pop_front());
        taken++;
        if (taken % 32 == 0) push_idle_pct = pick_idle_pct();
        if (!quiet_phase && $urandom_range(0, 99) < push_idle_pct)
          push_gap = $urandom_range(1, 18);
      end
      quiet_phase = request_q.size() < QUIET_ITEMS;
      if (push_gap != 0) begin
        push <= 1'b0;
        push_gap--;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].drain && packed_byte_q.size() != 0)) begin
        push <= 1'b1;
        op_i <= request_q[0].op;
        symbol_i <= request_q[0].symbol;
        code_bits_i <= request_q[0].code_bits;
        code_length_i <= request_q[0].code_length;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Check results in order, stall the result side, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (packed_byte_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", packed_byte_o));
        end else begin
          if (packed_byte_o !== packed_byte_q[0].data)
            report_mismatch($sformatf("packed_byte %02h, want %02h",
                                      packed_byte_o, packed_byte_q[0].data));
          if (last_of_run_o !== packed_byte_q[0].last_flag)
            report_mismatch($sformatf("last_of_run %b, want %b on byte %02h",
                                      last_of_run_o, packed_byte_q[0].last_flag,
                                      packed_byte_q[0].data));
          void'(packed_byte_q.pop_front());
        end
        popped++;
        if (popped % 32 == 0) pop_idle_pct = pick_idle_pct();
      end
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
      if (pop_gap != 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else if (!quiet_phase && $urandom_range(0, 99) < pop_idle_pct) begin
        pop <= 1'b0;
        pop_gap = $urandom_range(1, 18) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Build the stimulus, run reset, wait for the drain and judge
  initial begin
    logic [SYM_W-1:0]  alphabet [ALPHABET];
    logic [SYM_W-1:0]  sym;
    logic [CLEN_W-1:0] len;
    int                r;
    for (int i = 0; i < SYMBOLS; i++) begin
      code_tbl[i] = '0;
      len_tbl[i] = '0;
    end

    // Directed: empty table, idle flush, unused op, extreme and odd loads
    add_request(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
    add_request(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    add_request(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b0);
    add_request(OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0);
    add_request(OP_LOAD, 8'hFF, 32'h0000_0000, 6'd1, 1'b0);
    add_request(OP_LOAD, 8'h5A, 32'hFFFF_FFFF, 6'd3, 1'b0);
    add_request(OP_LOAD, 8'hA5, 32'hDEAD_BEEF, 6'd63, 1'b0);
    add_request(OP_LOAD, 8'h11, 32'h1234_5678, 6'd0, 1'b0);
    add_request(OP_LOAD, 8'h80, 32'h0000_007F, 6'd7, 1'b0);
    add_request(OP_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
    add_request(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
    add_request(OP_ENCODE, 8'h80, 32'h0, 6'd0, 1'b0);
    add_request(OP_ENCODE, 8'h80, 32'h0, 6'd0, 1'b0);
    // seven bits pending plus a full-length code: four bytes
    add_request(OP_ENCODE, 8'hA5, 32'h0, 6'd0, 1'b0);
    add_request(OP_ENCODE, 8'h11, 32'h0, 6'd0, 1'b0);
    add_request(OP_ENCODE, 8'h5A, 32'h0, 6'd0, 1'b0);
    add_request(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    add_request(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    add_request(OP_LOAD, 8'h5A, 32'h8000_0001, 6'd33, 1'b0);
    add_request(OP_ENCODE, 8'h5A, 32'h0, 6'd0, 1'b0);
    add_request(OP_LOAD, 8'h11, 32'hFFFF_FFFF, 6'd2, 1'b0);
    add_request(OP_ENCODE, 8'h11, 32'h0, 6'd0, 1'b0);
    add_request(OP_ENCODE, 8'h11, 32'h0, 6'd0, 1'b0);
    add_request(OP_ENCODE, 8'h11, 32'h0, 6'd0, 1'b0);
    add_request(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);

    // Random: load a small alphabet, then mostly encode from it
    for (int i = 0; i < ALPHABET; i++) begin
      alphabet[i] = 8'($urandom_range(0, 255));
      add_request(OP_LOAD, alphabet[i], $urandom, 6'($urandom_range(1, 12)), i == 0);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      sym = ($urandom_range(0, 9) < 8) ? alphabet[$urandom_range(0, ALPHABET - 1)]
                                        : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 7) len = 6'($urandom_range(1, 12));
      else if ($urandom_range(0, 1) == 0) len = 6'($urandom_range(13, 32));
      else len = 6'($urandom_range(0, 63));
      if (r < 18) add_request(OP_LOAD, sym, $urandom, len, i == 40 || i == 80);
      else if (r < 84) add_request(OP_ENCODE, sym, $urandom, 6'($urandom), i == 40 || i == 80);
      else if (r < 95) add_request(OP_FLUSH, sym, $urandom, 6'($urandom), i == 40 || i == 80);
      else add_request(OP_UNUSED, sym, $urandom, 6'($urandom), i == 40 || i == 80);
    end
    add_request(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);

    push_idle_pct = pick_idle_pct();
    pop_idle_pct = pick_idle_pct();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((request_q.size() != 0 || packed_byte_q.size() != 0) && !timed_out)
      @(posedge clk_i);
    if (timed_out) begin
      $display("RESULT: ERROR");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (mismatches == 0 && packed_byte_q.size() == 0 && !timed_out) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
    end
    $finish;
  end

endmodule
